[rtl/ridrt_pkg.sv]
`timescale 1ns / 1ps
package ridrt_pkg;

  localparam int CALL_SLOTS   = 256;
  localparam int HOST_SLOTS   = 16;
  localparam int ALARM_SLOTS  = 32;
  localparam int CANCEL_SLOTS = 32;

  localparam int MAX_SLOTS =
    (CALL_SLOTS >= HOST_SLOTS && CALL_SLOTS >= ALARM_SLOTS && CALL_SLOTS >= CANCEL_SLOTS) ?
      CALL_SLOTS :
    (HOST_SLOTS >= ALARM_SLOTS && HOST_SLOTS >= CANCEL_SLOTS) ? HOST_SLOTS :
    (ALARM_SLOTS >= CANCEL_SLOTS) ? ALARM_SLOTS : CANCEL_SLOTS;
  localparam int SCAN_W = $clog2(MAX_SLOTS + 1);

  localparam int KEY_W    = 24;
  localparam int REGION_W = 32;

  localparam logic [KEY_W-1:0] KEY_MASK_EXACT = 24'hffffff;
  localparam logic [KEY_W-1:0] KEY_MASK_MULTI = 24'hfffff0;
  localparam logic [1:0]       KEY_MODE_MULTI = 2'd2;

  // operations
  localparam logic [2:0] OP_REGISTER = 3'd0;
  localparam logic [2:0] OP_DEL_REG  = 3'd1;
  localparam logic [2:0] OP_DEL_ALL  = 3'd2;
  localparam logic [2:0] OP_FIND     = 3'd3;
  localparam logic [2:0] OP_CLASSIFY = 3'd4;

  // status codes
  localparam logic [2:0] ST_REGISTERED = 3'd0;
  localparam logic [2:0] ST_DUPLICATE  = 3'd1;
  localparam logic [2:0] ST_FULL       = 3'd2;
  localparam logic [2:0] ST_FOUND      = 3'd3;
  localparam logic [2:0] ST_NOT_FOUND  = 3'd4;
  localparam logic [2:0] ST_CLEARED    = 3'd5;

  // table indexes
  localparam logic [1:0] TBL_CALL   = 2'd0;
  localparam logic [1:0] TBL_HOST   = 2'd1;
  localparam logic [1:0] TBL_ALARM  = 2'd2;
  localparam logic [1:0] TBL_CANCEL = 2'd3;

  // classify answers
  localparam logic [1:0] FT_NONE   = 2'd0;
  localparam logic [1:0] FT_CANCEL = 2'd1;
  localparam logic [1:0] FT_ALARM  = 2'd2;
  localparam logic [1:0] FT_CALL   = 2'd3;

  typedef struct packed {
    logic                valid;
    logic [KEY_W-1:0]    key;
    logic [REGION_W-1:0] region;
  } entry_t;

  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_KEY,
    CMD_DEL_REG,
    CMD_CLR_ALL,
    CMD_WRITE
  } cmd_t;

  typedef struct packed {
    logic                hit;
    logic                empty_seen;
    logic [KEY_W-1:0]    key;
    logic [REGION_W-1:0] region;
  } scan_res_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_CHECK,
    S_WRITE,
    S_DONE
  } state_t;

endpackage

[rtl/ridrt_if.sv]
`timescale 1ns / 1ps
interface ridrt_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  operation;
  logic [1:0]  table_select;
  logic [23:0] key;
  logic [31:0] region;
  modport source (output valid, operation, table_select, key, region, input ready);
  modport sink (input valid, operation, table_select, key, region, output ready);
endinterface

interface ridrt_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [1:0]  found_table;
  logic [23:0] key_out;
  logic [31:0] region_out;
  modport source (output valid, status, found_table, key_out, region_out, input ready);
  modport sink (input valid, status, found_table, key_out, region_out, output ready);
endinterface

[rtl/ridrt_cell.sv]
`timescale 1ns / 1ps
module ridrt_cell (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            shift_en,
  input  ridrt_pkg::entry_t d,
  output ridrt_pkg::entry_t q
);
  import ridrt_pkg::*;

  entry_t ent_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_r.valid <= 1'b0;
    end else if (shift_en) begin
      ent_r.valid <= d.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (shift_en) begin
      ent_r.key    <= d.key;
      ent_r.region <= d.region;
    end
  end

  assign q = ent_r;

endmodule

[rtl/ridrt_scan.sv]
`timescale 1ns / 1ps
module ridrt_scan (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic                         active,
  input  ridrt_pkg::cmd_t              cmd,
  input  logic [ridrt_pkg::KEY_W-1:0]    key_cmp,
  input  logic [ridrt_pkg::KEY_W-1:0]    key_mask,
  input  logic [ridrt_pkg::REGION_W-1:0] region,
  input  ridrt_pkg::entry_t            head,
  output ridrt_pkg::entry_t            wb,
  output ridrt_pkg::scan_res_t         res
);
  import ridrt_pkg::*;

  logic                hit_r;
  logic                empty_r;
  logic [KEY_W-1:0]    key_r;
  logic [REGION_W-1:0] region_r;
  logic                key_match;
  logic                reg_match;
  logic                hit_set;

  always_comb begin
    key_match = head.valid && ((head.key & key_mask) == key_cmp);
    reg_match = head.valid && (head.region == region);
    wb        = head;
    hit_set   = 1'b0;
    unique case (cmd)
      CMD_NONE: ;
      CMD_KEY: begin
        if (key_match && !hit_r) hit_set = 1'b1;
      end
      CMD_DEL_REG: begin
        if (reg_match && !hit_r) begin
          hit_set = 1'b1;
          wb      = '0;
        end
      end
      CMD_CLR_ALL: wb = '0;
      CMD_WRITE: begin
        if (!head.valid && !hit_r) begin
          hit_set   = 1'b1;
          wb.valid  = 1'b1;
          wb.key    = key_cmp;
          wb.region = region;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_r   <= 1'b0;
      empty_r <= 1'b0;
    end else if (start) begin
      hit_r   <= 1'b0;
      empty_r <= 1'b0;
    end else if (active) begin
      if (hit_set) hit_r <= 1'b1;
      if (!head.valid) empty_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (active && hit_set) begin
      key_r    <= head.key;
      region_r <= head.region;
    end
  end

  assign res.hit        = hit_r;
  assign res.empty_seen = empty_r;
  assign res.key        = key_r;
  assign res.region     = region_r;

endmodule

[rtl/remote_id_registry_table.sv]
`timescale 1ns / 1ps
// remote transmitter registry: call, host, alarm and cancel tables of records
// (valid, 24-bit key, 32-bit region)
// in_ch carries one operation per item: register, delete by region, delete
// all, find or classify; out_ch returns exactly one result item per input item
// cfg_we / cfg_wdata write key_mode (2 = low key nibble ignored), reset value 2
// each table is a ring of cells that rotates one slot per cycle while it is
// scanned; the control inspects and rewrites the cell at the head of each ring
// each item takes one scan of the largest table, then a check; a register
// that finds no duplicate and a free slot takes a second scan, which writes it
// the scan of the call ring sets the rate, one item at a time
// reset empties all tables at once and leaves no result pending
// a stalled receiver: the finished result sits in the output register and the
// next item is still accepted; its result waits until the register is taken
module remote_id_registry_table (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [1:0] cfg_wdata,
  ridrt_in_if.sink   in_ch,
  ridrt_out_if.source out_ch
);
  import ridrt_pkg::*;

  localparam logic [SCAN_W-1:0] SCAN_LAST = SCAN_W'(MAX_SLOTS - 1);

  state_t              state_r, state_nxt;
  logic [SCAN_W-1:0]   cnt_r, cnt_nxt;
  logic [1:0]          key_mode_r;
  logic [2:0]          op_r;
  logic [1:0]          sel_r;
  logic [KEY_W-1:0]    key_cmp_r;
  logic [KEY_W-1:0]    key_mask_r;
  logic [REGION_W-1:0] region_r;
  logic                pass2_r, pass2_nxt;

  logic                out_valid_r;
  logic [2:0]          status_r;
  logic [1:0]          ftab_r;
  logic [KEY_W-1:0]    kout_r;
  logic [REGION_W-1:0] rout_r;

  logic                accept;
  logic                start;
  logic                load_out;
  logic [KEY_W-1:0]    in_mask;

  // per table: head cell, write-back value, rotate enable, command, results
  entry_t    head [4];
  entry_t    wb   [4];
  logic      shift[4];
  cmd_t      cmd  [4];
  scan_res_t res  [4];
  logic [SCAN_W-1:0] depth [4];

  logic [2:0]          st_c;
  logic [1:0]          ft_c;
  logic [KEY_W-1:0]    ko_c;
  logic [REGION_W-1:0] ro_c;

  assign depth[0] = SCAN_W'(CALL_SLOTS);
  assign depth[1] = SCAN_W'(HOST_SLOTS);
  assign depth[2] = SCAN_W'(ALARM_SLOTS);
  assign depth[3] = SCAN_W'(CANCEL_SLOTS);

  assign in_ch.ready = (state_r == S_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign in_mask     = (key_mode_r == KEY_MODE_MULTI) ? KEY_MASK_MULTI : KEY_MASK_EXACT;

  // config register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_mode_r <= KEY_MODE_MULTI;
    end else if (cfg_we) begin
      key_mode_r <= cfg_wdata;
    end
  end

  // item capture; key is normalized once with the mode in force at accept
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r       <= in_ch.operation;
      sel_r      <= in_ch.table_select;
      key_cmp_r  <= in_ch.key & in_mask;
      key_mask_r <= in_mask;
      region_r   <= in_ch.region;
    end
  end

  // the rings
  entry_t call_q   [CALL_SLOTS];
  entry_t host_q   [HOST_SLOTS];
  entry_t alarm_q  [ALARM_SLOTS];
  entry_t cancel_q [CANCEL_SLOTS];

  genvar j;
  generate
    for (j = 0; j < CALL_SLOTS; j++) begin : g_call
      ridrt_cell u_cell (
        .clk(clk), .rst_n(rst_n), .shift_en(shift[0]),
        .d((j == CALL_SLOTS - 1) ? wb[0] : call_q[(j + 1) % CALL_SLOTS]),
        .q(call_q[j])
      );
    end
    for (j = 0; j < HOST_SLOTS; j++) begin : g_host
      ridrt_cell u_cell (
        .clk(clk), .rst_n(rst_n), .shift_en(shift[1]),
        .d((j == HOST_SLOTS - 1) ? wb[1] : host_q[(j + 1) % HOST_SLOTS]),
        .q(host_q[j])
      );
    end
    for (j = 0; j < ALARM_SLOTS; j++) begin : g_alarm
      ridrt_cell u_cell (
        .clk(clk), .rst_n(rst_n), .shift_en(shift[2]),
        .d((j == ALARM_SLOTS - 1) ? wb[2] : alarm_q[(j + 1) % ALARM_SLOTS]),
        .q(alarm_q[j])
      );
    end
    for (j = 0; j < CANCEL_SLOTS; j++) begin : g_cancel
      ridrt_cell u_cell (
        .clk(clk), .rst_n(rst_n), .shift_en(shift[3]),
        .d((j == CANCEL_SLOTS - 1) ? wb[3] : cancel_q[(j + 1) % CANCEL_SLOTS]),
        .q(cancel_q[j])
      );
    end
  endgenerate

  assign head[0] = call_q[0];
  assign head[1] = host_q[0];
  assign head[2] = alarm_q[0];
  assign head[3] = cancel_q[0];

  // head inspection per table
  genvar t;
  generate
    for (t = 0; t < 4; t++) begin : g_scan
      assign shift[t] = ((state_r == S_SCAN) || (state_r == S_WRITE)) && (cnt_r < depth[t]);
      ridrt_scan u_scan (
        .clk(clk), .rst_n(rst_n), .start(start), .active(shift[t]),
        .cmd(cmd[t]), .key_cmp(key_cmp_r), .key_mask(key_mask_r),
        .region(region_r), .head(head[t]), .wb(wb[t]), .res(res[t])
      );
    end
  endgenerate

  // command routing per table
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      cmd[i] = CMD_NONE;
      if (state_r == S_WRITE) begin
        if (sel_r == 2'(i)) cmd[i] = CMD_WRITE;
      end else begin
        unique case (op_r)
          OP_REGISTER, OP_FIND: if (sel_r == 2'(i)) cmd[i] = CMD_KEY;
          OP_DEL_REG:           if (sel_r == 2'(i)) cmd[i] = CMD_DEL_REG;
          OP_DEL_ALL:           if (sel_r == 2'(i)) cmd[i] = CMD_CLR_ALL;
          OP_CLASSIFY:          if (2'(i) != TBL_HOST) cmd[i] = CMD_KEY;
          default: ;
        endcase
      end
    end
  end

  // result composition
  always_comb begin
    st_c = ST_NOT_FOUND;
    ft_c = FT_NONE;
    ko_c = '0;
    ro_c = '0;
    unique case (op_r)
      OP_REGISTER: begin
        if (pass2_r) begin
          st_c = ST_REGISTERED;
        end else if (res[sel_r].hit) begin
          st_c = ST_DUPLICATE;
          ko_c = res[sel_r].key;
          ro_c = res[sel_r].region;
        end else begin
          st_c = ST_FULL;
        end
      end
      OP_DEL_REG, OP_FIND: begin
        if (res[sel_r].hit) begin
          st_c = ST_FOUND;
          ko_c = res[sel_r].key;
          ro_c = res[sel_r].region;
        end
      end
      OP_DEL_ALL: st_c = ST_CLEARED;
      OP_CLASSIFY: begin
        // cancel wins over alarm, alarm over call
        priority if (res[TBL_CANCEL].hit) begin
          st_c = ST_FOUND; ft_c = FT_CANCEL;
          ko_c = res[TBL_CANCEL].key; ro_c = res[TBL_CANCEL].region;
        end else if (res[TBL_ALARM].hit) begin
          st_c = ST_FOUND; ft_c = FT_ALARM;
          ko_c = res[TBL_ALARM].key; ro_c = res[TBL_ALARM].region;
        end else if (res[TBL_CALL].hit) begin
          st_c = ST_FOUND; ft_c = FT_CALL;
          ko_c = res[TBL_CALL].key; ro_c = res[TBL_CALL].region;
        end else begin
          st_c = ST_NOT_FOUND;
        end
      end
      default: ;
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      pass2_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      pass2_r <= pass2_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    pass2_nxt = pass2_r;
    start     = 1'b0;
    load_out  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          start     = 1'b1;
          cnt_nxt   = '0;
          pass2_nxt = 1'b0;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == SCAN_LAST) state_nxt = S_CHECK;
      end
      S_CHECK: begin
        // free slot and no duplicate: second pass writes the first free slot
        if (op_r == OP_REGISTER && !res[sel_r].hit && res[sel_r].empty_seen) begin
          start     = 1'b1;
          cnt_nxt   = '0;
          pass2_nxt = 1'b1;
          state_nxt = S_WRITE;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_WRITE: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == SCAN_LAST) state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          load_out  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      status_r <= st_c;
      ftab_r   <= ft_c;
      kout_r   <= ko_c;
      rout_r   <= ro_c;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = status_r;
  assign out_ch.found_table = ftab_r;
  assign out_ch.key_out     = kout_r;
  assign out_ch.region_out  = rout_r;

  // checks
  a_accept_starts_scan: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == S_SCAN) && (cnt_r == '0))
    else $error("item accepted but scan not started");

  a_scan_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) && (cnt_r == SCAN_LAST) |=> (state_r == S_CHECK))
    else $error("scan did not end after the largest table");

  a_load_valid: assert property (@(posedge clk) disable iff (!rst_n)
    load_out |=> out_valid_r)
    else $error("result loaded but not offered");

  a_write_only_register: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WRITE) |-> (op_r == OP_REGISTER) && pass2_r)
    else $error("write pass outside register");

endmodule
